FILE: rtl/directory_entry_cache_table_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the directory entry cache table
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef DIRECTORY_ENTRY_CACHE_TABLE_DEFINES_SVH
`define DIRECTORY_ENTRY_CACHE_TABLE_DEFINES_SVH

// same-cycle implication
`define DECT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dect assertion failed");

// next-cycle implication
`define DECT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dect assertion failed");

`endif

FILE: rtl/dect_pkg.sv
// ---------------------------------------------------------------------------
// Directory entry cache table package
// Entry layout, request layout, command and status codes, sequencer states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dect_pkg;

	typedef enum logic [2:0] {
		CMD_ADD       = 3'd0,
		CMD_UPDATE    = 3'd1,
		CMD_REMOVE    = 3'd2,
		CMD_FIND_ID   = 3'd3,
		CMD_FIND_NAME = 3'd4
	} dect_cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} dect_status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_WRITE,
		S_RESP
	} dect_state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] parent;
		logic [31:0] rec_sector;
		logic [31:0] name_offset;
		logic [31:0] end_sector;
		logic [63:0] key;
	} dect_entry_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] id;
		logic [31:0] parent;
		logic [31:0] rec_sector;
		logic [31:0] name_offset;
		logic [31:0] end_sector;
		logic [63:0] key;
		logic        long_name;
	} dect_req_t;

	typedef struct packed {
		logic hit;
		logic free;
	} dect_match_t;

	localparam logic [31:0] ALL_ONES32 = 32'hffff_ffff;

endpackage

FILE: rtl/directory_entry_cache_table.sv
// Each command scans every slot through the single table RAM port, then takes
// a write-back step and a response step that loads the output register; no
// new command is taken until that result is loaded.
// A new command is taken while the previous result waits in the output register.
// Reset: a clearing pass over every slot sets it to all-ones;
// in_ready stays low until it ends.
// ---------------------------------------------------------------------------
// Directory entry cache table
// Add, update, remove and look up directory entries held in one RAM.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module directory_entry_cache_table #(
	parameter int TABLE_ENTRIES    = 64,
	parameter int SHORT_NAME_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] item_id,
	input  logic [31:0] parent_id,
	input  logic [31:0] name_sector_in,
	input  logic [31:0] name_offset_in,
	input  logic [31:0] tail_sector_in,
	input  logic [63:0] name_key,
	input  logic        long_name,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  slot,
	output logic [31:0] found_id,
	output logic [31:0] found_parent_id,
	output logic [31:0] found_name_sector,
	output logic [31:0] found_name_offset,
	output logic [31:0] found_tail_sector,
	output logic        needs_confirm
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	dect_pkg::dect_state_t state_q, state_d;

	dect_pkg::dect_entry_t mem_q [TABLE_ENTRIES];
	dect_pkg::dect_entry_t rd_data_s1;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	logic [IDX_W-1:0]      idx_q;
	dect_pkg::dect_req_t   req_q;

	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	dect_pkg::dect_entry_t hit_entry_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	dect_pkg::dect_match_t match;

	logic                  accept;
	logic                  mem_we;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_addr;
	dect_pkg::dect_entry_t mem_wdata;
	logic                  load_out;

	logic                  do_write;
	logic [IDX_W-1:0]      wr_idx;
	dect_pkg::dect_entry_t wr_data;
	dect_pkg::dect_status_t res_status;
	logic [IDX_W-1:0]      res_idx;
	dect_pkg::dect_entry_t res_entry;
	logic                  res_confirm;
	dect_pkg::dect_entry_t merged;
	dect_pkg::dect_entry_t new_entry;
	logic                  id_ones;
	logic [IDX_W+5:0]      res_idx_ext;

	logic                  out_valid_q;

	// --------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dect_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = idx_q;
		mem_wdata = '1;
		load_out = 1'b0;
		case (state_q)
			dect_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = dect_pkg::S_IDLE;
				end
			end
			dect_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = dect_pkg::S_SCAN;
				end
			end
			dect_pkg::S_SCAN: begin
				mem_re = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = dect_pkg::S_LAST;
				end
			end
			dect_pkg::S_LAST: begin
				state_d = dect_pkg::S_WRITE;
			end
			dect_pkg::S_WRITE: begin
				mem_we    = do_write;
				mem_addr  = wr_idx;
				mem_wdata = wr_data;
				state_d   = dect_pkg::S_RESP;
			end
			dect_pkg::S_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = dect_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dect_pkg::S_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= '0;
		end else if (state_q == dect_pkg::S_CLEAR || state_q == dect_pkg::S_SCAN) begin
			idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
		end
	end

	// hold the command beat for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.cmd         <= command;
			req_q.id          <= item_id;
			req_q.parent      <= parent_id;
			req_q.rec_sector  <= name_sector_in;
			req_q.name_offset <= name_offset_in;
			req_q.end_sector  <= tail_sector_in;
			req_q.key         <= name_key;
			req_q.long_name   <= long_name;
		end
	end

	// ------------------------------------------------------------- table RAM
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem_q[mem_addr];
		end
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
		end
	end

	// ------------------------------------------------------------- slot match
	dect_match #(
		.SHORT_NAME_BYTES(SHORT_NAME_BYTES)
	) u_match (
		.entry(rd_data_s1),
		.req  (req_q),
		.match(match)
	);

	// keep the first hit and the first free slot in ascending order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_valid_s1) begin
			if (match.hit && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (match.free && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && match.hit && !hit_q) begin
			hit_idx_q   <= rd_idx_s1;
			hit_entry_q <= rd_data_s1;
		end
		if (rd_valid_s1 && match.free && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// ------------------------------------------------------ write-back, result
	always_comb begin
		id_ones = (req_q.id == dect_pkg::ALL_ONES32);

		new_entry.id          = req_q.id;
		new_entry.parent      = req_q.parent;
		new_entry.rec_sector  = req_q.rec_sector;
		new_entry.name_offset = req_q.name_offset;
		new_entry.end_sector  = req_q.end_sector;
		new_entry.key         = req_q.key;

		// sector and offset go together; all-ones means keep
		merged = hit_entry_q;
		if (req_q.rec_sector != dect_pkg::ALL_ONES32) begin
			merged.rec_sector  = req_q.rec_sector;
			merged.name_offset = req_q.name_offset;
		end
		if (req_q.end_sector != dect_pkg::ALL_ONES32) begin
			merged.end_sector = req_q.end_sector;
		end

		do_write    = 1'b0;
		wr_idx      = hit_idx_q;
		wr_data     = '1;
		res_status  = dect_pkg::STAT_NOT_FOUND;
		res_idx     = hit_idx_q;
		res_entry   = hit_entry_q;
		res_confirm = 1'b0;

		case (req_q.cmd)
			dect_pkg::CMD_ADD: begin
				if (hit_q) begin
					res_status = dect_pkg::STAT_OK;
				end else if (!id_ones && free_q) begin
					res_status = dect_pkg::STAT_OK;
					res_idx    = free_idx_q;
					res_entry  = new_entry;
					do_write   = 1'b1;
					wr_idx     = free_idx_q;
					wr_data    = new_entry;
				end else if (!id_ones) begin
					res_status = dect_pkg::STAT_FULL;
				end
			end
			dect_pkg::CMD_UPDATE: begin
				if (hit_q) begin
					res_status = dect_pkg::STAT_OK;
					res_entry  = merged;
					do_write   = 1'b1;
					wr_data    = merged;
				end
			end
			dect_pkg::CMD_REMOVE: begin
				if (hit_q) begin
					res_status = dect_pkg::STAT_OK;
					do_write   = 1'b1;
				end
			end
			dect_pkg::CMD_FIND_ID: begin
				if (hit_q) begin
					res_status = dect_pkg::STAT_OK;
				end
			end
			dect_pkg::CMD_FIND_NAME: begin
				if (hit_q) begin
					res_status  = dect_pkg::STAT_OK;
					res_confirm = req_q.long_name;
				end
			end
			default: begin
				res_status = dect_pkg::STAT_NOT_FOUND;
			end
		endcase

		res_idx_ext = {6'd0, res_idx};
	end

	// ----------------------------------------------------------- output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status <= res_status;
			if (res_status == dect_pkg::STAT_OK) begin
				slot              <= res_idx_ext[5:0];
				found_id          <= res_entry.id;
				found_parent_id   <= res_entry.parent;
				found_name_sector <= res_entry.rec_sector;
				found_name_offset <= res_entry.name_offset;
				found_tail_sector <= res_entry.end_sector;
				needs_confirm     <= res_confirm;
			end else begin
				slot              <= '0;
				found_id          <= '0;
				found_parent_id   <= '0;
				found_name_sector <= '0;
				found_name_offset <= '0;
				found_tail_sector <= '0;
				needs_confirm     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/dect_match.sv
// ---------------------------------------------------------------------------
// Directory entry cache table slot matcher
// Compares one stored entry against the pending request and flags a hit
// for the command and whether the slot is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dect_match #(
	parameter int SHORT_NAME_BYTES = 8
) (
	input  dect_pkg::dect_entry_t entry,
	input  dect_pkg::dect_req_t   req,
	output dect_pkg::dect_match_t match
);

	localparam logic [63:0] SHORT_MASK = (SHORT_NAME_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * SHORT_NAME_BYTES)) - 64'd1);

	logic        entry_free;
	logic        id_hit;
	logic        name_hit;
	logic [63:0] key_mask;

	always_comb begin
		entry_free = (entry.id == dect_pkg::ALL_ONES32);
		id_hit     = (entry.id == req.id) && (req.id != dect_pkg::ALL_ONES32);
		key_mask   = req.long_name ? {64{1'b1}} : SHORT_MASK;
		name_hit   = !entry_free && (entry.parent == req.parent) &&
			(((entry.key ^ req.key) & key_mask) == 64'd0);

		match.free = entry_free;
		case (req.cmd)
			dect_pkg::CMD_ADD,
			dect_pkg::CMD_UPDATE,
			dect_pkg::CMD_REMOVE,
			dect_pkg::CMD_FIND_ID: begin
				match.hit = id_hit;
			end
			dect_pkg::CMD_FIND_NAME: begin
				match.hit = name_hit;
			end
			default: begin
				match.hit = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/dect_checker.sv
// ---------------------------------------------------------------------------
// Directory entry cache table port checker
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "directory_entry_cache_table_defines.svh"

module dect_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [5:0]  slot,
	input logic [31:0] found_id,
	input logic        needs_confirm
);

	// a stalled result beat stays offered
	`DECT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

	// one command at a time: busy right after a command beat
	`DECT_ASSERT_NXT(a_busy_after_cmd, in_valid && in_ready, !in_ready)

	// a miss or a drop carries no slot contents
	`DECT_ASSERT_IMP(a_miss_zero, out_valid && (status != dect_pkg::STAT_OK),
		(slot == 6'd0) && (found_id == 32'd0) && !needs_confirm)

	// a hashed match is only ever reported as found
	`DECT_ASSERT_IMP(a_confirm_found, out_valid && needs_confirm, status == dect_pkg::STAT_OK)

endmodule

bind directory_entry_cache_table dect_checker u_dect_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.slot         (slot),
	.found_id     (found_id),
	.needs_confirm(needs_confirm)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Directory entry cache table testbench
// Runs a directed table of commands and then random command mixes through the
// block. A shadow copy of the entry table predicts every result beat, and the
// receiver compares each beat field by field. Sender and receiver stall at
// random in changing proportions.
// ---------------------------------------------------------------------------

module testbench;
	import dect_pkg::*;

	localparam int TBL_ENTRIES  = 64;
	localparam int NAME_BYTES   = 8;
	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASES       = 3;
	localparam int ID_POOL      = 96;
	localparam int PARENTS      = 4;

	localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
	localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
	localparam logic [63:0] SHORT_MASK   =
		(NAME_BYTES >= 8) ? '1 : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

	localparam logic [31:0] DIR_PARENT = 32'h0000_0010;
	localparam logic [63:0] KEY_A      = 64'hffff_ffff_ffff_ff61;
	localparam logic [63:0] KEY_AB     = 64'hffff_ffff_ffff_6261;
	localparam logic [63:0] KEY_ABC    = 64'hffff_ffff_ff63_6261;
	localparam logic [63:0] LONG_HASH  = 64'h0123_4567_89ab_cdef;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [31:0] id;
		logic [31:0] parent;
		logic [31:0] rec_sector;
		logic [31:0] name_offset;
		logic [31:0] end_sector;
		logic        confirm;
	} dir_answer_t;

	typedef struct {
		dect_req_t   rq;
		bit          typed;
		dir_answer_t want;
	} dir_row_t;

	localparam dir_answer_t MISS =
		'{STAT_NOT_FOUND, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0};

	logic        clk;
	logic        arst_n            = 1'b0;
	logic        in_valid          = 1'b0;
	logic        in_ready;
	logic [2:0]  command           = '0;
	logic [31:0] item_id           = '0;
	logic [31:0] parent_id         = '0;
	logic [31:0] name_sector_in    = '0;
	logic [31:0] name_offset_in    = '0;
	logic [31:0] tail_sector_in    = '0;
	logic [63:0] name_key          = '0;
	logic        long_name         = 1'b0;
	logic        out_valid;
	logic        out_ready         = 1'b0;
	logic [1:0]  status;
	logic [5:0]  slot;
	logic [31:0] found_id;
	logic [31:0] found_parent_id;
	logic [31:0] found_name_sector;
	logic [31:0] found_name_offset;
	logic [31:0] found_tail_sector;
	logic        needs_confirm;

	dect_entry_t shadow_dir [TBL_ENTRIES];
	dir_answer_t answers_due [$];
	dir_row_t    script [$];

	logic [31:0] id_pool     [ID_POOL];
	logic [63:0] key_pool    [ID_POOL];
	logic        long_pool   [ID_POOL];
	logic [31:0] parent_pool [PARENTS];

	int send_idle = 34;
	int recv_idle = 74;
	int n_errors  = 0;
	int n_checked = 0;
	int n_issued  = 0;
	int n_full    = 0;
	int n_confirm = 0;

	directory_entry_cache_table #(
		.TABLE_ENTRIES    (TBL_ENTRIES),
		.SHORT_NAME_BYTES (NAME_BYTES)
	) i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout: %0d result beats still due", answers_due.size());
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
		n_errors++;
	endtask

	function automatic int slot_holding(input logic [31:0] id);
		for (int i = 0; i < TBL_ENTRIES; i++)
			if (shadow_dir[i].id == id)
				return i;
		return -1;
	endfunction

	// Apply one command to the shadow table and return the beat it causes.
	function automatic dir_answer_t apply_command(input dect_req_t rq);
		dir_answer_t ans;
		int          hit;
		int          spot;
		logic [63:0] mask;
		ans = '0;
		ans.status = STAT_NOT_FOUND;
		hit = -1;
		mask = rq.long_name ? '1 : SHORT_MASK;
		case (rq.cmd)
			CMD_ADD: if (rq.id != ALL_ONES32) begin
				hit = slot_holding(rq.id);
				if (hit < 0) begin
					spot = slot_holding(ALL_ONES32);
					if (spot < 0) begin
						ans.status = STAT_FULL;
					end else begin
						shadow_dir[spot] = '{rq.id, rq.parent, rq.rec_sector,
							rq.name_offset, rq.end_sector, rq.key};
						hit = spot;
					end
				end
			end
			CMD_UPDATE: if (rq.id != ALL_ONES32) begin
				hit = slot_holding(rq.id);
				if (hit >= 0) begin
					// sector and offset move together; all-ones means keep
					if (rq.rec_sector != ALL_ONES32) begin
						shadow_dir[hit].rec_sector  = rq.rec_sector;
						shadow_dir[hit].name_offset = rq.name_offset;
					end
					if (rq.end_sector != ALL_ONES32)
						shadow_dir[hit].end_sector = rq.end_sector;
				end
			end
			CMD_REMOVE, CMD_FIND_ID: if (rq.id != ALL_ONES32) begin
				hit = slot_holding(rq.id);
			end
			CMD_FIND_NAME: begin
				for (int i = 0; i < TBL_ENTRIES && hit < 0; i++)
					if (shadow_dir[i].id != ALL_ONES32 && shadow_dir[i].parent == rq.parent
							&& ((shadow_dir[i].key ^ rq.key) & mask) == '0)
						hit = i;
			end
			default: ;
		endcase
		if (hit >= 0) begin
			ans.status      = STAT_OK;
			ans.slot        = hit[5:0];
			ans.id          = shadow_dir[hit].id;
			ans.parent      = shadow_dir[hit].parent;
			ans.rec_sector  = shadow_dir[hit].rec_sector;
			ans.name_offset = shadow_dir[hit].name_offset;
			ans.end_sector  = shadow_dir[hit].end_sector;
			ans.confirm     = (rq.cmd == CMD_FIND_NAME) && rq.long_name;
		end
		// remove answers with the contents it clears
		if (rq.cmd == CMD_REMOVE && hit >= 0)
			shadow_dir[hit] = '1;
		return ans;
	endfunction

	function automatic dect_req_t mk_req(input logic [2:0] c, input logic [31:0] id,
			input logic [31:0] par, input logic [31:0] nsec, input logic [31:0] noff,
			input logic [31:0] tail, input logic [63:0] key, input logic lng);
		return '{c, id, par, nsec, noff, tail, key, lng};
	endfunction

	function automatic dir_answer_t hit_at(input logic [5:0] s, input logic [31:0] id,
			input logic [31:0] fill);
		return '{STAT_OK, s, id, fill, fill, fill, fill, 1'b0};
	endfunction

	task automatic row_typed(input dect_req_t rq, input dir_answer_t want);
		script.push_back('{rq, 1'b1, want});
	endtask

	task automatic row_predicted(input dect_req_t rq);
		script.push_back('{rq, 1'b0, MISS});
	endtask

	function automatic dect_req_t random_command(input int phase);
		dect_req_t rq;
		int        idx;
		int        roll;
		int        drop_share;
		idx = $urandom_range(ID_POOL - 1);
		drop_share = (phase == 1) ? 30 : (phase == 0) ? 8 : 15;
		rq.id          = id_pool[idx];
		rq.parent      = parent_pool[idx % PARENTS];
		rq.rec_sector  = $urandom;
		rq.name_offset = $urandom;
		rq.end_sector  = $urandom;
		rq.key         = key_pool[idx];
		rq.long_name   = long_pool[idx];
		roll = $urandom_range(99);
		if (roll < 2)
			rq.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		else if (roll < 40)
			rq.cmd = CMD_ADD;
		else if (roll < 55)
			rq.cmd = CMD_UPDATE;
		else if (roll < 55 + drop_share)
			rq.cmd = CMD_REMOVE;
		else if (roll[0])
			rq.cmd = CMD_FIND_ID;
		else
			rq.cmd = CMD_FIND_NAME;
		roll = $urandom_range(99);
		if (roll < 4)
			rq.id = ALL_ONES32;
		else if (roll < 10)
			rq.id = $urandom;
		if ($urandom_range(9) == 0)
			rq.parent = $urandom;
		if (rq.cmd == CMD_ADD && $urandom_range(9) == 0)
			rq.key = key_pool[$urandom_range(ID_POOL - 1)];
		if (rq.cmd == CMD_FIND_NAME) begin
			if ($urandom_range(9) == 0)
				rq.key = {$urandom, $urandom};
			if ($urandom_range(9) == 0)
				rq.long_name = ~rq.long_name;
		end
		if ($urandom_range(3) == 0)
			rq.rec_sector = ALL_ONES32;
		if ($urandom_range(3) == 0)
			rq.end_sector = ALL_ONES32;
		return rq;
	endfunction

	task automatic issue(input dect_req_t rq, input bit typed, input dir_answer_t want);
		dir_answer_t predicted;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= rq.cmd;
		item_id        <= rq.id;
		parent_id      <= rq.parent;
		name_sector_in <= rq.rec_sector;
		name_offset_in <= rq.name_offset;
		tail_sector_in <= rq.end_sector;
		name_key       <= rq.key;
		long_name      <= rq.long_name;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_command(rq);
		answers_due.push_back(typed ? want : predicted);
		n_issued++;
		if (predicted.status == STAT_FULL)
			n_full++;
		if (predicted.confirm)
			n_confirm++;
	endtask

	always @(posedge clk) begin : watch_results
		dir_answer_t want;
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected beat", {62'd0, status}, '0);
			end else begin
				want = answers_due.pop_front();
				n_checked++;
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (slot !== want.slot)
					report_mismatch("slot", 64'(slot), 64'(want.slot));
				if (found_id !== want.id)
					report_mismatch("found_id", 64'(found_id), 64'(want.id));
				if (found_parent_id !== want.parent)
					report_mismatch("found_parent_id", 64'(found_parent_id),
						64'(want.parent));
				if (found_name_sector !== want.rec_sector)
					report_mismatch("found_name_sector", 64'(found_name_sector),
						64'(want.rec_sector));
				if (found_name_offset !== want.name_offset)
					report_mismatch("found_name_offset", 64'(found_name_offset),
						64'(want.name_offset));
				if (found_tail_sector !== want.end_sector)
					report_mismatch("found_tail_sector", 64'(found_tail_sector),
						64'(want.end_sector));
				if (needs_confirm !== want.confirm)
					report_mismatch("needs_confirm", 64'(needs_confirm), 64'(want.confirm));
			end
		end
	end

	initial begin : run_commands
		int len;
		for (int i = 0; i < TBL_ENTRIES; i++)
			shadow_dir[i] = '1;

		// empty table, unknown ids and spare codes
		row_typed(mk_req(CMD_FIND_ID, 32'h0, 32'h0, '0, '0, '0, 64'h0, 1'b0), MISS);
		row_typed(mk_req(CMD_FIND_NAME, 32'h0, 32'h0, '0, '0, '0, 64'h0, 1'b0), MISS);
		row_typed(mk_req(CMD_UPDATE, 32'h5, 32'h0, '0, '0, '0, 64'h0, 1'b0), MISS);
		row_typed(mk_req(CMD_REMOVE, 32'h5, 32'h0, '0, '0, '0, 64'h0, 1'b0), MISS);
		row_typed(mk_req(CMD_SPARE_LO, 32'h0, 32'h0, '0, '0, '0, 64'h0, 1'b0), MISS);
		row_typed(mk_req(CMD_SPARE_HI, '1, '1, '1, '1, '1, '1, 1'b1), MISS);
		row_typed(mk_req(CMD_ADD, ALL_ONES32, 32'h0, '0, '0, '0, 64'h0, 1'b0), MISS);
		// field extremes, then an add of an id already present
		row_typed(mk_req(CMD_ADD, 32'h0, 32'h0, '0, '0, '0, 64'h0, 1'b0),
			hit_at(6'd0, 32'h0, 32'h0));
		row_typed(mk_req(CMD_ADD, 32'hffff_fffe, '1, '1, '1, '1, '1, 1'b1),
			hit_at(6'd1, 32'hffff_fffe, ALL_ONES32));
		row_typed(mk_req(CMD_ADD, 32'h0, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
			32'h4444_4444, 64'h5555_5555_5555_5555, 1'b0), hit_at(6'd0, 32'h0, 32'h0));
		// short name that is a prefix of another must not match it
		row_predicted(mk_req(CMD_ADD, 32'h0000_1234, DIR_PARENT, 32'h100, 32'h8, 32'h200,
			KEY_AB, 1'b0));
		row_predicted(mk_req(CMD_ADD, 32'h0000_1235, DIR_PARENT, 32'h101, 32'h9, 32'h201,
			KEY_ABC, 1'b0));
		row_predicted(mk_req(CMD_FIND_NAME, '0, DIR_PARENT, '0, '0, '0, KEY_AB, 1'b0));
		row_predicted(mk_req(CMD_FIND_NAME, '0, DIR_PARENT, '0, '0, '0, KEY_ABC, 1'b0));
		row_predicted(mk_req(CMD_FIND_NAME, '0, DIR_PARENT, '0, '0, '0, KEY_A, 1'b0));
		// hashed long name flags confirmation
		row_predicted(mk_req(CMD_ADD, 32'h0000_1236, DIR_PARENT, 32'h102, 32'ha, 32'h202,
			LONG_HASH, 1'b1));
		row_predicted(mk_req(CMD_FIND_NAME, '0, DIR_PARENT, '0, '0, '0, LONG_HASH, 1'b1));
		// partial updates: keep sector, then keep tail
		row_predicted(mk_req(CMD_UPDATE, 32'h0000_1235, '0, ALL_ONES32, 32'h77, 32'h55,
			64'h0, 1'b0));
		row_predicted(mk_req(CMD_UPDATE, 32'h0000_1235, '0, 32'haaaa_aaaa, 32'h5555_5555,
			ALL_ONES32, 64'h0, 1'b0));
		row_predicted(mk_req(CMD_FIND_ID, 32'h0000_1235, '0, '0, '0, '0, 64'h0, 1'b0));
		row_typed(mk_req(CMD_UPDATE, ALL_ONES32, '0, '0, '0, '0, 64'h0, 1'b0), MISS);
		// a cleared slot is all-ones and must never match
		row_predicted(mk_req(CMD_REMOVE, 32'hffff_fffe, '0, '0, '0, '0, 64'h0, 1'b0));
		row_typed(mk_req(CMD_FIND_NAME, '0, ALL_ONES32, '0, '0, '0, '1, 1'b0), MISS);
		row_typed(mk_req(CMD_FIND_ID, 32'hffff_fffe, '0, '0, '0, '0, 64'h0, 1'b0), MISS);
		row_typed(mk_req(CMD_FIND_ID, ALL_ONES32, '0, '0, '0, '0, 64'h0, 1'b0), MISS);

		// a third of the names are hashes, a third short names from a tiny
		// alphabet so prefixes collide, a third short names of any byte but 00 and ff
		for (int i = 0; i < ID_POOL; i++) begin
			id_pool[i] = $urandom;
			if (id_pool[i] == ALL_ONES32)
				id_pool[i] = 32'h0;
			long_pool[i] = (i % 3 == 0);
			if (i % 3 == 0) begin
				key_pool[i] = {$urandom, $urandom};
			end else begin
				key_pool[i] = '1;
				len = (i % 3 == 1) ? $urandom_range(1, 4) : $urandom_range(1, NAME_BYTES);
				for (int b = 0; b < len; b++)
					key_pool[i][8 * b +: 8] = (i % 3 == 1) ?
						8'(8'h61 + $urandom_range(3)) : 8'($urandom_range(8'h01, 8'hfe));
			end
		end
		for (int p = 0; p < PARENTS; p++)
			parent_pool[p] = $urandom;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[r])
			issue(script[r].rq, script[r].typed, script[r].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle = (ph == 0) ? 34 : (ph == 1) ? 74 : 0;
			recv_idle = (ph == 0) ? 74 : (ph == 1) ? 34 : 0;
			for (int n = 0; n < RANDOM_ITEMS / PHASES + 1; n++)
				issue(random_command(ph), 1'b0, MISS);
		end
		in_valid <= 1'b0;

		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (TBL_ENTRIES + 8) @(posedge clk);

		$display("covered %0d commands: %0d adds dropped on a full table, %0d hash matches",
			n_issued, n_full, n_confirm);
		$display("checked %0d result beats, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
